>>> hdl/sfcc_pkg.sv
`default_nettype none
package sfcc_pkg;

  localparam int FRAME_LEN = 8;
  localparam int CRC_LEN   = 6;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [IDX_W-1:0] IDX_FIRST  = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_HUM_HI = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_HUM_LO = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_TMP_HI = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_TMP_LO = IDX_W'(5);
  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_CRC_END = IDX_W'(CRC_LEN);

  localparam logic [15:0] HUMIDITY_RESET    = 16'd300;
  localparam logic [15:0] TEMPERATURE_RESET = 16'd400;

  typedef logic [IDX_W-1:0] byte_idx_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    byte_idx_t  idx;
  } stage_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hdl/sfcc_byte_if.sv
`default_nettype none
interface sfcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source(output valid, data_byte, frame_start, input ready);
  modport sink(input valid, data_byte, frame_start, output ready);
endinterface
`default_nettype wire

>>> hdl/sfcc_result_if.sv
`default_nettype none
interface sfcc_result_if;
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic [15:0] humidity_tenths;
  logic signed [15:0] temperature_tenths;

  modport source(output valid, crc_ok, humidity_tenths, temperature_tenths, input ready);
  modport sink(input valid, crc_ok, humidity_tenths, temperature_tenths, output ready);
endinterface
`default_nettype wire

>>> hdl/sensor_frame_crc_checker.sv
`default_nettype none
// Takes one frame byte per cycle, unless intake stalls as below, with no gaps between frames.
// The result of a frame is registered once its last byte has passed the framer's stage register and been taken.
// Intake stalls only while a finished result is unread and a frame's last byte waits.
// Synchronous reset clears the byte count, sets the CRC to 0xFFFF and the held
// readings to 30.0 percent and 40.0 degrees.
module sensor_frame_crc_checker (
  input  wire logic     clk,
  input  wire logic     rst,
  sfcc_byte_if.sink     frame_bytes,
  sfcc_result_if.source results
);

  sfcc_pkg::stage_t stage;
  logic             take;

  sfcc_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .frame_bytes (frame_bytes),
    .take        (take),
    .stage       (stage)
  );

  sfcc_decoder u_decoder (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .take    (take),
    .results (results)
  );

endmodule
`default_nettype wire

>>> hdl/sfcc_framer.sv
`default_nettype none
module sfcc_framer (
  input  wire logic            clk,
  input  wire logic            rst,
  sfcc_byte_if.sink            frame_bytes,
  input  wire logic            take,
  output sfcc_pkg::stage_t     stage
);

  sfcc_pkg::byte_idx_t count;
  sfcc_pkg::byte_idx_t idx;
  logic                accept;

  // A word with the start mark is byte 0 whatever the running count says.
  assign idx = frame_bytes.frame_start ? sfcc_pkg::IDX_FIRST : count;
  assign frame_bytes.ready = !stage.valid || take;
  assign accept = frame_bytes.valid && frame_bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= sfcc_pkg::IDX_FIRST;
      stage.valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= idx + sfcc_pkg::byte_idx_t'(1);
      end
      if (frame_bytes.ready) begin
        stage.valid <= frame_bytes.valid;
      end
    end
    if (accept) begin
      stage.data <= frame_bytes.data_byte;
      stage.idx  <= idx;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sfcc_decoder.sv
`default_nettype none
module sfcc_decoder (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sfcc_pkg::stage_t stage,
  output logic                 take,
  sfcc_result_if.source        results
);

  logic [15:0] crc;
  logic [15:0] crc_start;
  logic [15:0] crc_next;
  logic [15:0] humidity_capture;
  logic [15:0] temperature_capture;
  logic [7:0]  crc_low_capture;
  logic [15:0] held_humidity;
  logic [15:0] held_temperature;
  logic [15:0] held_humidity_next;
  logic [15:0] held_temperature_next;
  logic [15:0] magnitude;
  logic        is_last;
  logic        ok;

  assign is_last = stage.idx == sfcc_pkg::IDX_LAST;
  // A byte that closes a frame waits only while the previous result is still unread.
  assign take = stage.valid && (!is_last || !results.valid || results.ready);

  assign crc_start = (stage.idx == sfcc_pkg::IDX_FIRST) ? sfcc_pkg::CRC_INIT : crc;
  assign crc_next  = sfcc_pkg::crc_byte(crc_start, stage.data);
  assign ok        = {stage.data, crc_low_capture} == crc;
  assign magnitude = {1'b0, temperature_capture[14:0]};

  always_comb begin
    held_humidity_next    = held_humidity;
    held_temperature_next = held_temperature;
    if (ok) begin
      held_humidity_next = humidity_capture;
      if (temperature_capture[15]) begin
        held_temperature_next = 16'd0 - magnitude;
      end else begin
        held_temperature_next = magnitude;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc                 <= sfcc_pkg::CRC_INIT;
      humidity_capture    <= 16'd0;
      temperature_capture <= 16'd0;
      crc_low_capture     <= 8'd0;
      held_humidity       <= sfcc_pkg::HUMIDITY_RESET;
      held_temperature    <= sfcc_pkg::TEMPERATURE_RESET;
      results.valid       <= 1'b0;
    end else begin
      if (take && is_last) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      if (take) begin
        if (stage.idx < sfcc_pkg::IDX_CRC_END) begin
          crc <= crc_next;
        end else if (is_last) begin
          crc <= sfcc_pkg::CRC_INIT;
        end
        unique case (stage.idx)
          sfcc_pkg::IDX_HUM_HI: humidity_capture[15:8]    <= stage.data;
          sfcc_pkg::IDX_HUM_LO: humidity_capture[7:0]     <= stage.data;
          sfcc_pkg::IDX_TMP_HI: temperature_capture[15:8] <= stage.data;
          sfcc_pkg::IDX_TMP_LO: temperature_capture[7:0]  <= stage.data;
          sfcc_pkg::IDX_CRC_LO: crc_low_capture           <= stage.data;
          default: ;
        endcase
        if (is_last) begin
          held_humidity              <= held_humidity_next;
          held_temperature           <= held_temperature_next;
          results.crc_ok             <= ok;
          results.humidity_tenths    <= held_humidity_next;
          results.temperature_tenths <= held_temperature_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sim/sensor_frame_crc_checker_tb.sv
`timescale 1ns / 1ps

module sensor_frame_crc_checker_tb;

  localparam logic [7:0] SENSOR_READ_FN  = 8'h03;
  localparam logic [7:0] SENSOR_READ_LEN = 8'h04;
  localparam int TOTAL_WORDS = 450;
  localparam int QUIET_AFTER = 380;
  localparam int HOLD_AFTER  = 150;
  localparam int LONG_HOLD   = 80;

  typedef struct {
    logic        crc_ok;
    logic [15:0] humidity;
    logic [15:0] temperature;
  } sensor_reading_t;

  class reading_tracker;
    sfcc_pkg::byte_idx_t byte_pos;
    logic [15:0]       crc_run;
    logic [15:0]       hum_cap;
    logic [15:0]       temp_cap;
    logic [7:0]        crc_lo_cap;
    logic [15:0]       held_hum;
    logic [15:0]       held_temp;
    sensor_reading_t   due_readings[$];
    int                errors;

    function new();
      byte_pos   = sfcc_pkg::IDX_FIRST;
      crc_run    = sfcc_pkg::CRC_INIT;
      hum_cap    = 16'h0000;
      temp_cap   = 16'h0000;
      crc_lo_cap = 8'h00;
      held_hum   = sfcc_pkg::HUMIDITY_RESET;
      held_temp  = sfcc_pkg::TEMPERATURE_RESET;
      errors     = 0;
    endfunction

    function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] d);
      logic [15:0] c;
      c = crc ^ {8'h00, d};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ sfcc_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function int pending();
      return due_readings.size();
    endfunction

    function void note_byte(logic [7:0] d, logic start);
      sfcc_pkg::byte_idx_t pos;
      logic [15:0]     mag;
      logic [15:0]     received;
      sensor_reading_t r;
      pos = start ? sfcc_pkg::IDX_FIRST : byte_pos;
      if (pos == sfcc_pkg::IDX_FIRST) begin
        crc_run = sfcc_pkg::CRC_INIT;
      end
      if (pos < sfcc_pkg::IDX_CRC_END) begin
        crc_run = crc_step(crc_run, d);
      end
      unique case (pos)
        sfcc_pkg::IDX_HUM_HI: hum_cap[15:8] = d;
        sfcc_pkg::IDX_HUM_LO: hum_cap[7:0] = d;
        sfcc_pkg::IDX_TMP_HI: temp_cap[15:8] = d;
        sfcc_pkg::IDX_TMP_LO: temp_cap[7:0] = d;
        sfcc_pkg::IDX_CRC_LO: crc_lo_cap = d;
        default: ;
      endcase
      if (pos == sfcc_pkg::IDX_LAST) begin
        received = {d, crc_lo_cap};
        if (received == crc_run) begin
          held_hum = hum_cap;
          mag = {1'b0, temp_cap[14:0]};
          held_temp = temp_cap[15] ? (16'h0000 - mag) : mag;
        end
        r.crc_ok      = (received == crc_run);
        r.humidity    = held_hum;
        r.temperature = held_temp;
        due_readings.push_back(r);
        crc_run = sfcc_pkg::CRC_INIT;
      end
      byte_pos = pos + sfcc_pkg::byte_idx_t'(1);
    endfunction

    function void check_reading(logic ok, logic [15:0] hum, logic [15:0] temp);
      sensor_reading_t e;
      if (due_readings.size() == 0) begin
        $error("reading arrived with none outstanding: crc_ok %0d humidity %0d temperature %0d",
               ok, hum, $signed(temp));
        errors++;
        return;
      end
      e = due_readings.pop_front();
      if (ok !== e.crc_ok) begin
        $error("crc_ok expected %0d actual %0d", e.crc_ok, ok);
        errors++;
      end
      if (hum !== e.humidity) begin
        $error("humidity_tenths expected %0d actual %0d", e.humidity, hum);
        errors++;
      end
      if (temp !== e.temperature) begin
        $error("temperature_tenths expected %0d actual %0d",
               $signed(e.temperature), $signed(temp));
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfcc_byte_if   frame_bytes();
  sfcc_result_if results();

  reading_tracker tracker;
  int  words_sent = 0;
  bit  quiet = 1'b0;
  bit  hold_request = 1'b0;

  sensor_frame_crc_checker u_dut (
    .clk(clk),
    .rst(rst),
    .frame_bytes(frame_bytes.sink),
    .results(results.source)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && tracker != null) begin
      if (frame_bytes.valid && frame_bytes.ready) begin
        tracker.note_byte(frame_bytes.data_byte, frame_bytes.frame_start);
      end
      if (results.valid && results.ready) begin
        tracker.check_reading(results.crc_ok, results.humidity_tenths,
                              results.temperature_tenths);
      end
    end
  end

  initial begin
    results.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        results.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        results.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        results.ready <= 1'b1;
      end else begin
        results.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin
    #3_000_000;
    $display("sensor_frame_crc_checker regression: fail");
    $finish;
  end

  task automatic send_byte(input logic [7:0] d, input logic start);
    frame_bytes.valid       <= 1'b1;
    frame_bytes.data_byte   <= d;
    frame_bytes.frame_start <= start;
    @(posedge clk);
    while (!frame_bytes.ready) @(posedge clk);
    words_sent++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      frame_bytes.valid       <= 1'b0;
      frame_bytes.data_byte   <= 8'($urandom);
      frame_bytes.frame_start <= 1'($urandom);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] fn, input logic [7:0] len,
                            input logic [15:0] hum, input logic [15:0] temp_raw,
                            input bit corrupt, input bit mark, input int n);
    logic [7:0]  fb [8];
    logic [15:0] crc;
    int          bi;
    fb[0] = fn;
    fb[1] = len;
    fb[2] = hum[15:8];
    fb[3] = hum[7:0];
    fb[4] = temp_raw[15:8];
    fb[5] = temp_raw[7:0];
    crc = sfcc_pkg::CRC_INIT;
    for (int i = 0; i < sfcc_pkg::CRC_LEN; i++) begin
      crc = tracker.crc_step(crc, fb[i]);
    end
    fb[6] = crc[7:0];
    fb[7] = crc[15:8];
    if (corrupt) begin
      bi = $urandom_range(0, sfcc_pkg::FRAME_LEN - 1);
      fb[bi] = fb[bi] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (int i = 0; i < n; i++) begin
      send_byte(fb[i], mark && i == 0);
    end
  endtask

  initial begin
    int          kind;
    int          wait_cycles;
    bit          hold_done;
    logic [15:0] hum;
    logic [7:0]  fn;
    logic [7:0]  len;

    hold_done = 1'b0;
    tracker = new();
    frame_bytes.valid       <= 1'b0;
    frame_bytes.data_byte   <= 8'h00;
    frame_bytes.frame_start <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A bad frame straight out of reset must report the reset readings.
    send_frame(SENSOR_READ_FN, SENSOR_READ_LEN, 16'h0000, 16'h0000, 1'b1, 1'b1,
               sfcc_pkg::FRAME_LEN);
    send_frame(SENSOR_READ_FN, SENSOR_READ_LEN, 16'h0000, 16'h0000, 1'b0, 1'b1,
               sfcc_pkg::FRAME_LEN);
    send_frame(SENSOR_READ_FN, SENSOR_READ_LEN, 16'hFFFF, 16'h7FFF, 1'b0, 1'b1,
               sfcc_pkg::FRAME_LEN);
    send_frame(SENSOR_READ_FN, SENSOR_READ_LEN, 16'h01F4, 16'hFFFF, 1'b0, 1'b1,
               sfcc_pkg::FRAME_LEN);
    send_frame(SENSOR_READ_FN, SENSOR_READ_LEN, 16'h0123, 16'h8000, 1'b0, 1'b1,
               sfcc_pkg::FRAME_LEN);
    send_frame(SENSOR_READ_FN, SENSOR_READ_LEN, 16'h0456, 16'h00C8, 1'b1, 1'b1,
               sfcc_pkg::FRAME_LEN);
    // A frame cut short is abandoned by a new start mark.
    send_frame(SENSOR_READ_FN, SENSOR_READ_LEN, 16'h0222, 16'h8111, 1'b0, 1'b1, 3);
    send_frame(SENSOR_READ_FN, SENSOR_READ_LEN, 16'h0333, 16'h80FA, 1'b0, 1'b1,
               sfcc_pkg::FRAME_LEN);
    // The count wraps on its own, so an unmarked frame still lines up.
    send_frame(SENSOR_READ_FN, SENSOR_READ_LEN, 16'h0250, 16'h0101, 1'b0, 1'b0,
               sfcc_pkg::FRAME_LEN);
    for (int i = 0; i < sfcc_pkg::FRAME_LEN; i++) begin
      send_byte(8'hFF, i == 0);
    end

    while (words_sent < TOTAL_WORDS) begin
      if (!hold_done && words_sent > HOLD_AFTER) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      if (words_sent > QUIET_AFTER) begin
        quiet = 1'b1;
      end
      kind = $urandom_range(0, 19);
      hum  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1000));
      fn   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : SENSOR_READ_FN;
      len  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : SENSOR_READ_LEN;
      if (kind < 14) begin
        send_frame(fn, len, hum, 16'($urandom), 1'b0, $urandom_range(0, 3) != 0,
                   sfcc_pkg::FRAME_LEN);
      end else if (kind < 17) begin
        send_frame(fn, len, hum, 16'($urandom), 1'b1, 1'b1, sfcc_pkg::FRAME_LEN);
      end else if (kind < 19) begin
        send_frame(fn, len, hum, 16'($urandom), 1'b0, 1'b1,
                   $urandom_range(1, sfcc_pkg::FRAME_LEN - 1));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'($urandom));
      end
    end
    frame_bytes.valid <= 1'b0;

    wait_cycles = 0;
    while (tracker.pending() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d readings never arrived", tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("sensor_frame_crc_checker regression: pass");
    end else begin
      $display("sensor_frame_crc_checker regression: fail");
    end
    $finish;
  end

endmodule

>>> sensor_frame_crc_checker.f
hdl/sfcc_pkg.sv
hdl/sfcc_byte_if.sv
hdl/sfcc_result_if.sv
hdl/sfcc_framer.sv
hdl/sfcc_decoder.sv
hdl/sensor_frame_crc_checker.sv
sim/sensor_frame_crc_checker_tb.sv
